>>> hw/rtl/ppid_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppid_pkg
// Shared widths, register indexes, command codes and helpers for the
// positional PID controller.
// ---------------------------------------------------------------------------
package ppid_pkg;

  // Data widths.
  localparam int unsigned DataW     = 32;
  localparam int unsigned GainW     = 31;
  localparam int unsigned OptW      = 7;
  localparam int unsigned MulW      = 34;
  localparam int unsigned ProdW     = 2 * MulW;
  localparam int unsigned QuoW      = 64;
  localparam int unsigned DivisorW  = 32;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned StallCntW = 10;
  localparam int unsigned StateW    = 5;

  localparam logic [StallCntW-1:0] StallCntMax = '1;
  localparam logic [StallCntW-1:0] StallLimit  = StallCntW'(500);

  // Defaults for the top level parameters.
  localparam int unsigned DefRateCoefA     = 65536;
  localparam int unsigned DefRateCoefB     = 65536;
  localparam int unsigned DefOutFilterRc   = 0;
  localparam int unsigned DefDerivFilterRc = 0;

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_GAIN_P   = 3'd0;
  localparam logic [2:0] REG_GAIN_I   = 3'd1;
  localparam logic [2:0] REG_GAIN_D   = 3'd2;
  localparam logic [2:0] REG_OUT_LIM  = 3'd3;
  localparam logic [2:0] REG_INT_CAP  = 3'd4;
  localparam logic [2:0] REG_DEAD     = 3'd5;
  localparam logic [2:0] REG_OPTIONS  = 3'd6;

  // Option bit positions.
  localparam int unsigned OPT_STALL    = 0;
  localparam int unsigned OPT_TRAP     = 1;
  localparam int unsigned OPT_VRATE    = 2;
  localparam int unsigned OPT_DMEAS    = 3;
  localparam int unsigned OPT_DFILT    = 4;
  localparam int unsigned OPT_ILIMIT   = 5;
  localparam int unsigned OPT_OFILT    = 6;

  // Multiplier operand selection.
  localparam logic [2:0] MUL_P   = 3'd0;
  localparam logic [2:0] MUL_I   = 3'd1;
  localparam logic [2:0] MUL_IT  = 3'd2;
  localparam logic [2:0] MUL_D   = 3'd3;
  localparam logic [2:0] MUL_VR  = 3'd4;
  localparam logic [2:0] MUL_LPC = 3'd5;
  localparam logic [2:0] MUL_LPL = 3'd6;

  // Divisor selection.
  localparam logic [1:0] DIV_DT = 2'd0;
  localparam logic [1:0] DIV_A  = 2'd1;
  localparam logic [1:0] DIV_LP = 2'd2;

  // Datapath register updates.
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LATCH   = 4'd1;
  localparam logic [3:0] OP_STALL   = 4'd2;
  localparam logic [3:0] OP_POUT    = 4'd3;
  localparam logic [3:0] OP_IQ      = 4'd4;
  localparam logic [3:0] OP_ITERM   = 4'd5;
  localparam logic [3:0] OP_DOUT    = 4'd6;
  localparam logic [3:0] OP_VR_ZERO = 4'd7;
  localparam logic [3:0] OP_VR_Q    = 4'd8;
  localparam logic [3:0] OP_LP_LOAD = 4'd9;
  localparam logic [3:0] OP_LP_ADD  = 4'd10;
  localparam logic [3:0] OP_LP_RES  = 4'd11;
  localparam logic [3:0] OP_INTEG   = 4'd12;
  localparam logic [3:0] OP_SUM     = 4'd13;
  localparam logic [3:0] OP_FINISH  = 4'd14;

  typedef struct packed {
    logic [GainW-1:0] gain_p;
    logic [GainW-1:0] gain_i;
    logic [GainW-1:0] gain_d;
    logic [GainW-1:0] output_limit;
    logic [GainW-1:0] integral_cap;
    logic [GainW-1:0] dead_band;
    logic [OptW-1:0]  opt;
  } cfg_t;

  typedef struct packed {
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       div_start;
    logic [1:0] div_sel;
    logic       lp_out;
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic            in_band;
    logic            vr_on;
    logic            vr_in;
    logic            div_busy;
    logic            div_done;
    logic            out_free;
    logic [OptW-1:0] opt;
  } stat_t;

  localparam logic signed [ProdW-1:0] SatHi = ProdW'(32'sh7FFF_FFFF);
  localparam logic signed [ProdW-1:0] SatLo = ProdW'(32'sh8000_0000);

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [DataW-1:0] sat32(input logic signed [ProdW-1:0] x);
    logic signed [DataW-1:0] r;
    if (x > SatHi) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SatLo) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(x[DataW-1:0]);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ppid_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppid_regs
// Configuration register file behind a simple APB-style port.
// ---------------------------------------------------------------------------
module ppid_regs import ppid_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [2:0] idx;
  logic       wr;
  cfg_t       regs;

  assign idx    = paddr[AddrW-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;

  // Register writes; addresses beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr) begin
      case (idx)
        REG_GAIN_P:  regs.gain_p       <= pwdata[GainW-1:0];
        REG_GAIN_I:  regs.gain_i       <= pwdata[GainW-1:0];
        REG_GAIN_D:  regs.gain_d       <= pwdata[GainW-1:0];
        REG_OUT_LIM: regs.output_limit <= pwdata[GainW-1:0];
        REG_INT_CAP: regs.integral_cap <= pwdata[GainW-1:0];
        REG_DEAD:    regs.dead_band    <= pwdata[GainW-1:0];
        REG_OPTIONS: regs.opt          <= pwdata[OptW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read-back.
  always_comb begin
    case (idx)
      REG_GAIN_P:  prdata = {1'b0, regs.gain_p};
      REG_GAIN_I:  prdata = {1'b0, regs.gain_i};
      REG_GAIN_D:  prdata = {1'b0, regs.gain_d};
      REG_OUT_LIM: prdata = {1'b0, regs.output_limit};
      REG_INT_CAP: prdata = {1'b0, regs.integral_cap};
      REG_DEAD:    prdata = {1'b0, regs.dead_band};
      REG_OPTIONS: prdata = {{(32-OptW){1'b0}}, regs.opt};
      default:     prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/ppid_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppid_div
// Iterative signed-by-unsigned divider, two quotient bits per cycle,
// truncating toward zero. Dividend magnitudes stay below 2^64.
// ---------------------------------------------------------------------------
module ppid_div import ppid_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ProdW-1:0] dividend,
  input  logic [DivisorW-1:0]     divisor,
  output logic                    busy,
  output logic                    done,
  output logic signed [QuoW:0]    quotient
);

  localparam int unsigned Cycles = QuoW / 2;
  localparam int unsigned CntW   = $clog2(Cycles);

  logic [QuoW-1:0]     num;
  logic [DivisorW-1:0] rem;
  logic [DivisorW-1:0] den;
  logic                neg;
  logic [CntW-1:0]     cnt;
  logic [ProdW-1:0]    mag;

  logic [DivisorW:0]   r1, r1s, r2, r2s;
  logic                ge1, ge2;
  logic [DivisorW-1:0] rem1;
  logic [QuoW-1:0]     num1, num2;

  assign mag = dividend[ProdW-1] ? ProdW'(-dividend) : ProdW'(dividend);

  // Two restoring steps per cycle.
  always_comb begin
    r1   = {rem, num[QuoW-1]};
    ge1  = r1 >= {1'b0, den};
    r1s  = ge1 ? r1 - {1'b0, den} : r1;
    rem1 = r1s[DivisorW-1:0];
    num1 = {num[QuoW-2:0], ge1};
    r2   = {rem1, num1[QuoW-1]};
    ge2  = r2 >= {1'b0, den};
    r2s  = ge2 ? r2 - {1'b0, den} : r2;
    num2 = {num1[QuoW-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(Cycles - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= mag[QuoW-1:0];
      rem <= '0;
      den <= divisor;
      neg <= dividend[ProdW-1];
    end else if (busy) begin
      num <= num2;
      rem <= r2s[DivisorW-1:0];
    end
  end

  assign quotient = neg ? -$signed({1'b0, num}) : $signed({1'b0, num});

endmodule

>>> hw/rtl/ppid_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppid_datapath
// Controller state, shared multiplier, shared divider and result register.
// All updates but the out_valid clear on handshake follow the sequencer's command.
// ---------------------------------------------------------------------------
module ppid_datapath import ppid_pkg::*; #(
  parameter int unsigned RATE_COEF_A     = DefRateCoefA,
  parameter int unsigned RATE_COEF_B     = DefRateCoefB,
  parameter int unsigned OUT_FILTER_RC   = DefOutFilterRc,
  parameter int unsigned DERIV_FILTER_RC = DefDerivFilterRc
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic signed [DataW-1:0] measured,
  input  logic signed [DataW-1:0] target,
  input  logic [GainW-1:0]        elapsed,
  output logic signed [DataW-1:0] drive,
  output logic                    stalled,
  output logic                    out_valid,
  input  logic                    out_ready
);

  localparam logic [DataW:0]   CoefA   = (DataW+1)'(RATE_COEF_A);
  localparam logic [DataW:0]   CoefB   = (DataW+1)'(RATE_COEF_B);
  localparam logic [DataW:0]   CoefAB  = CoefA + CoefB;
  localparam logic [GainW-1:0] OutRc   = GainW'(OUT_FILTER_RC);
  localparam logic [GainW-1:0] DerivRc = GainW'(DERIV_FILTER_RC);

  // Item and working registers.
  logic signed [DataW-1:0] meas, tgt, err, e_int, pout, iq, iterm, dout, sum;
  logic [GainW-1:0]        dt;
  logic [DataW-1:0]        abs_err;
  logic                    in_band;
  logic signed [ProdW-1:0] prod, lp;

  // Controller state.
  logic signed [DataW-1:0] prev_error, prev_measured, prev_drive, deriv_term;
  logic signed [DataW-1:0] integral_acc, held_target;
  logic [StallCntW-1:0]    stall_count;
  logic                    stall_flag;

  // Stall check on the stored values.
  logic [DataW-1:0]   abs_pd, abs_ht;
  logic signed [DataW:0] ht_diff;
  logic [DataW:0]     abs_htd;
  logic               stall_skip, stall_far;
  logic [StallCntW-1:0] cnt_inc;

  always_comb begin
    abs_pd     = prev_drive[DataW-1] ? DataW'(-prev_drive) : DataW'(prev_drive);
    abs_ht     = held_target[DataW-1] ? DataW'(-held_target) : DataW'(held_target);
    ht_diff    = (DataW+1)'(held_target) - (DataW+1)'(prev_measured);
    abs_htd    = ht_diff[DataW] ? (DataW+1)'(-ht_diff) : (DataW+1)'(ht_diff);
    stall_skip = (42'(abs_pd) * 42'd1000 < 42'(cfg.output_limit)) ||
                 (46'(abs_ht) * 46'd10000 < 46'd65536);
    stall_far  = 38'(abs_htd) * 38'd20 > 38'(abs_ht) * 38'd19;
    cnt_inc    = (stall_count == StallCntMax) ? stall_count : stall_count + 1'b1;
  end

  // Error and integration input from the latched item.
  logic signed [DataW:0]   err_diff, trap_sum;
  logic signed [DataW-1:0] err_new;
  logic [DataW-1:0]        abs_err_new;

  always_comb begin
    err_diff    = (DataW+1)'(tgt) - (DataW+1)'(meas);
    err_new     = sat32(ProdW'(err_diff));
    abs_err_new = err_new[DataW-1] ? DataW'(-err_new) : DataW'(err_new);
    trap_sum    = (DataW+1)'(err_new) + (DataW+1)'(prev_error);
  end

  // Changing integration rate conditions.
  logic       same_sign;
  logic [DataW:0] vr_factor;

  always_comb begin
    same_sign = (err > 0 && integral_acc > 0) || (err < 0 && integral_acc < 0);
    vr_factor = CoefAB - {1'b0, abs_err};
  end

  // Shared multiplier operand selection.
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [DataW:0]   d_diff;
  logic signed [DataW-1:0] lp_cur, lp_last;
  logic [GainW-1:0]        lp_rc;

  always_comb begin
    d_diff  = cfg.opt[OPT_DMEAS] ? (DataW+1)'(prev_measured) - (DataW+1)'(meas)
                                 : (DataW+1)'(err) - (DataW+1)'(prev_error);
    lp_cur  = cmd.lp_out ? sum : dout;
    lp_last = cmd.lp_out ? prev_drive : deriv_term;
    lp_rc   = cmd.lp_out ? OutRc : DerivRc;
    case (cmd.mul_sel)
      MUL_P: begin
        mul_a = $signed({{(MulW-GainW){1'b0}}, cfg.gain_p});
        mul_b = MulW'(err);
      end
      MUL_I: begin
        mul_a = $signed({{(MulW-GainW){1'b0}}, cfg.gain_i});
        mul_b = MulW'(e_int);
      end
      MUL_IT: begin
        mul_a = MulW'(iq);
        mul_b = $signed({{(MulW-GainW){1'b0}}, dt});
      end
      MUL_D: begin
        mul_a = $signed({{(MulW-GainW){1'b0}}, cfg.gain_d});
        mul_b = MulW'(d_diff);
      end
      MUL_VR: begin
        mul_a = MulW'(iterm);
        mul_b = $signed({{(MulW-DataW-1){1'b0}}, vr_factor});
      end
      MUL_LPC: begin
        mul_a = MulW'(lp_cur);
        mul_b = $signed({{(MulW-GainW){1'b0}}, dt});
      end
      MUL_LPL: begin
        mul_a = MulW'(lp_last);
        mul_b = $signed({{(MulW-GainW){1'b0}}, lp_rc});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Shared divider.
  logic signed [ProdW-1:0] div_num;
  logic [DivisorW-1:0]     div_den;
  logic                    div_busy, div_done;
  logic signed [QuoW:0]    quo;

  always_comb begin
    div_num = (cmd.div_sel == DIV_LP) ? lp : prod;
    case (cmd.div_sel)
      DIV_DT:  div_den = DivisorW'(dt);
      DIV_A:   div_den = CoefA[DivisorW-1:0];
      DIV_LP:  div_den = DivisorW'(lp_rc) + DivisorW'(dt);
      default: div_den = DivisorW'(dt);
    endcase
  end

  ppid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  // Integral limit and accumulation.
  logic signed [DataW+1:0] t_i, t_o, acc_sum;
  logic [DataW+1:0]        abs_t_o;
  logic signed [DataW+1:0] cap;
  logic signed [DataW-1:0] acc_base, it_use;

  always_comb begin
    t_i      = (DataW+2)'(integral_acc) + (DataW+2)'(iterm);
    t_o      = (DataW+2)'(pout) + (DataW+2)'(integral_acc) + (DataW+2)'(dout);
    abs_t_o  = t_o[DataW+1] ? (DataW+2)'(-t_o) : (DataW+2)'(t_o);
    cap      = $signed({3'b000, cfg.integral_cap});
    acc_base = integral_acc;
    it_use   = iterm;
    if (cfg.opt[OPT_ILIMIT]) begin
      if (abs_t_o > {3'b000, cfg.output_limit} && same_sign) begin
        it_use = '0;
      end
      if (t_i > cap) begin
        it_use   = '0;
        acc_base = $signed({1'b0, cfg.integral_cap});
      end
      if (t_i < -cap) begin
        it_use   = '0;
        acc_base = -$signed({1'b0, cfg.integral_cap});
      end
    end
    acc_sum = (DataW+2)'(acc_base) + (DataW+2)'(it_use);
  end

  // Output clamp.
  logic signed [DataW-1:0] lim, drive_val;
  logic signed [DataW+1:0] pid_sum;

  always_comb begin
    lim     = $signed({1'b0, cfg.output_limit});
    pid_sum = (DataW+2)'(pout) + (DataW+2)'(integral_acc) + (DataW+2)'(dout);
    if (in_band) begin
      drive_val = '0;
    end else if (sum > lim) begin
      drive_val = lim;
    end else if (sum < -lim) begin
      drive_val = -lim;
    end else begin
      drive_val = sum;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        meas <= measured;
        tgt  <= target;
        dt   <= (elapsed == '0) ? GainW'(1) : elapsed;
      end
      OP_STALL: begin
        err     <= err_new;
        abs_err <= abs_err_new;
        in_band <= abs_err_new <= {1'b0, cfg.dead_band};
        e_int   <= cfg.opt[OPT_TRAP] ? trap_sum[DataW:1] : err_new;
      end
      OP_POUT:    pout  <= sat32(prod >>> 16);
      OP_IQ:      iq    <= sat32(prod >>> 16);
      OP_ITERM:   iterm <= sat32(prod >>> 16);
      OP_DOUT:    dout  <= sat32(ProdW'(quo));
      OP_VR_ZERO: iterm <= '0;
      OP_VR_Q:    iterm <= quo[DataW-1:0];
      OP_LP_LOAD: lp    <= prod;
      OP_LP_ADD:  lp    <= lp + prod;
      OP_LP_RES: begin
        if (cmd.lp_out) begin
          sum <= sat32(ProdW'(quo));
        end else begin
          dout <= sat32(ProdW'(quo));
        end
      end
      OP_SUM: sum <= sat32(ProdW'(pid_sum));
      default: begin
      end
    endcase
  end

  // Controller state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error    <= '0;
      prev_measured <= '0;
      prev_drive    <= '0;
      deriv_term    <= '0;
      integral_acc  <= '0;
      held_target   <= '0;
      stall_count   <= '0;
      stall_flag    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_STALL: begin
          if (cfg.opt[OPT_STALL] && !stall_skip) begin
            if (stall_far) begin
              stall_count <= cnt_inc;
              if (cnt_inc > StallLimit) begin
                stall_flag <= 1'b1;
              end
            end else begin
              stall_count <= '0;
              stall_flag  <= 1'b0;
            end
          end
        end
        OP_INTEG: integral_acc <= sat32(ProdW'(acc_sum));
        OP_FINISH: begin
          held_target   <= stall_flag ? sat32(-ProdW'(tgt)) : tgt;
          prev_measured <= meas;
          prev_drive    <= drive_val;
          prev_error    <= err;
          if (!in_band) begin
            deriv_term <= dout;
          end
          out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      drive   <= drive_val;
      stalled <= stall_flag;
    end
  end

  assign stat.in_band  = in_band;
  assign stat.vr_on    = cfg.opt[OPT_VRATE] && same_sign && ({1'b0, abs_err} > CoefB);
  assign stat.vr_in    = {1'b0, abs_err} <= CoefAB;
  assign stat.div_busy = div_busy;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || out_ready;
  assign stat.opt      = cfg.opt;

endmodule

>>> hw/rtl/ppid_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppid_ctrl
// Sequencer for one control step: orders the multiplies, divisions and
// register updates of the datapath.
// ---------------------------------------------------------------------------
module ppid_ctrl import ppid_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [StateW-1:0] S_IDLE   = 5'd0;
  localparam logic [StateW-1:0] S_STALL  = 5'd1;
  localparam logic [StateW-1:0] S_PMUL   = 5'd2;
  localparam logic [StateW-1:0] S_IMUL   = 5'd3;
  localparam logic [StateW-1:0] S_IQ     = 5'd4;
  localparam logic [StateW-1:0] S_ITMUL  = 5'd5;
  localparam logic [StateW-1:0] S_DMUL   = 5'd6;
  localparam logic [StateW-1:0] S_DDIV   = 5'd7;
  localparam logic [StateW-1:0] S_DWAIT  = 5'd8;
  localparam logic [StateW-1:0] S_VR     = 5'd9;
  localparam logic [StateW-1:0] S_VRDIV  = 5'd10;
  localparam logic [StateW-1:0] S_VRWAIT = 5'd11;
  localparam logic [StateW-1:0] S_DF     = 5'd12;
  localparam logic [StateW-1:0] S_LP     = 5'd13;
  localparam logic [StateW-1:0] S_LPMUL  = 5'd14;
  localparam logic [StateW-1:0] S_LPADD  = 5'd15;
  localparam logic [StateW-1:0] S_LPDIV  = 5'd16;
  localparam logic [StateW-1:0] S_LPWAIT = 5'd17;
  localparam logic [StateW-1:0] S_INTEG  = 5'd18;
  localparam logic [StateW-1:0] S_SUM    = 5'd19;
  localparam logic [StateW-1:0] S_OF     = 5'd20;
  localparam logic [StateW-1:0] S_DONE   = 5'd21;

  logic [StateW-1:0] state, state_next;
  logic              lp_out, lp_out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      lp_out <= 1'b0;
    end else begin
      state  <= state_next;
      lp_out <= lp_out_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next    = state;
    lp_out_next   = lp_out;
    cmd           = '0;
    cmd.lp_out    = lp_out;
    cmd.op        = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_STALL;
        end
      end
      S_STALL: begin
        cmd.op     = OP_STALL;
        state_next = S_PMUL;
      end
      S_PMUL: begin
        if (stat.in_band) begin
          state_next = S_DONE;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_P;
          state_next  = S_IMUL;
        end
      end
      S_IMUL: begin
        cmd.op      = OP_POUT;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_I;
        state_next  = S_IQ;
      end
      S_IQ: begin
        cmd.op     = OP_IQ;
        state_next = S_ITMUL;
      end
      S_ITMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_IT;
        state_next  = S_DMUL;
      end
      S_DMUL: begin
        cmd.op      = OP_ITERM;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D;
        state_next  = S_DDIV;
      end
      S_DDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DT;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_DOUT;
          state_next = S_VR;
        end
      end
      S_VR: begin
        if (!stat.vr_on) begin
          state_next = S_DF;
        end else if (stat.vr_in) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_VR;
          state_next  = S_VRDIV;
        end else begin
          cmd.op     = OP_VR_ZERO;
          state_next = S_DF;
        end
      end
      S_VRDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_A;
        state_next    = S_VRWAIT;
      end
      S_VRWAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_VR_Q;
          state_next = S_DF;
        end
      end
      S_DF: begin
        if (stat.opt[OPT_DFILT]) begin
          lp_out_next = 1'b0;
          state_next  = S_LP;
        end else begin
          state_next = S_INTEG;
        end
      end
      S_LP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LPC;
        state_next  = S_LPMUL;
      end
      S_LPMUL: begin
        cmd.op      = OP_LP_LOAD;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LPL;
        state_next  = S_LPADD;
      end
      S_LPADD: begin
        cmd.op     = OP_LP_ADD;
        state_next = S_LPDIV;
      end
      S_LPDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_LP;
        state_next    = S_LPWAIT;
      end
      S_LPWAIT: begin
        cmd.div_sel = DIV_LP;
        if (stat.div_done) begin
          cmd.op     = OP_LP_RES;
          state_next = lp_out ? S_DONE : S_INTEG;
        end
      end
      S_INTEG: begin
        cmd.op     = OP_INTEG;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = OP_SUM;
        state_next = S_OF;
      end
      S_OF: begin
        if (stat.opt[OPT_OFILT]) begin
          lp_out_next = 1'b1;
          state_next  = S_LP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/positional_pid_with_options.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// positional_pid_with_options
// Positional PID controller in signed Q16.16 with stall detection,
// trapezoidal integration, changing integration rate, derivative on
// measurement, derivative and output low-pass, and integral limit.
//
//   Channel   Dir  Handshake                 Payload
//   s_*       in   s_tvalid / s_tready       measured, target, elapsed
//   m_*       out  m_tvalid / m_tready       drive (tdata), stalled (tuser)
//   APB       in   psel, penable, pwrite     seven configuration registers
//
// A step inside the dead band skips the multiplies and divisions. Otherwise
// the derivative division sets the length of a step; the changing integration
// rate, when it applies, and each enabled low-pass add a further division.
// Reset is synchronous and clears controller state, configuration and m_tvalid.
// One item is worked at a time; a finished result waits in the output
// register, and the next item is taken while it waits.
// ---------------------------------------------------------------------------
module positional_pid_with_options import ppid_pkg::*; #(
  parameter int unsigned RATE_COEF_A     = DefRateCoefA,
  parameter int unsigned RATE_COEF_B     = DefRateCoefB,
  parameter int unsigned OUT_FILTER_RC   = DefOutFilterRc,
  parameter int unsigned DERIV_FILTER_RC = DefDerivFilterRc
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [95:0]      s_tdata,   // measured[31:0], target[63:32], elapsed[94:64], pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,   // drive[31:0]
  output logic             m_tuser    // stalled[0]
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic signed [DataW-1:0] drive;

  ppid_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ppid_datapath #(
    .RATE_COEF_A     (RATE_COEF_A),
    .RATE_COEF_B     (RATE_COEF_B),
    .OUT_FILTER_RC   (OUT_FILTER_RC),
    .DERIV_FILTER_RC (DERIV_FILTER_RC)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .measured  ($signed(s_tdata[31:0])),
    .target    ($signed(s_tdata[63:32])),
    .elapsed   (s_tdata[94:64]),
    .drive     (drive),
    .stalled   (m_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  assign m_tdata = drive;

`ifndef SYNTH
  // An accepted request is followed by work before the input is ready again.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a step is in progress");

  // A new result only appears after the finishing update.
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.op == OP_FINISH))
    else $error("result raised without a finished step");

  // The divider is never restarted while busy.
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("division started while divider busy");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional PID controller. It programs the
// registers over APB, streams measurement requests with random gaps and
// output stalls, and compares every drive and stall flag with a
// cycle-free model of the controller kept inside the bench.
// ---------------------------------------------------------------------------
module testbench;
  import ppid_pkg::*;

  typedef logic signed [95:0] wide_t;

  typedef struct {
    logic signed [31:0] measured;
    logic signed [31:0] target;
    logic [30:0]        elapsed;
    bit                 hold;     // wait until all results are in before sending
  } sample_t;

  typedef struct {
    logic signed [31:0] drive;
    logic               stalled;
  } ctrl_out_t;

  localparam int SettleCycles = 300;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tuser;

  positional_pid_with_options uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Bench copy of the registers and controller state.
  wide_t kp, ki, kd, lim, icap, dband;
  logic [OptW-1:0] opts;
  wide_t err_prev, last_meas, last_drive, d_hold, i_acc, ref_hold;
  int    stall_cnt;
  bit    stall_on;

  sample_t   pending_samples[$];
  ctrl_out_t expected_drives[$];
  sample_t   cur;
  bit        s_took, m_took;
  int        send_gap, recv_stall;
  bit        idle_on;
  int        mismatches, n_sent, n_checked, n_stalled;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("positional_pid_with_options: mismatch");
    $finish;
  end

  function automatic wide_t sat(input wide_t x);
    if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return -64'sh8000_0000;
    return x;
  endfunction

  function automatic wide_t mag(input wide_t x);
    return x < 0 ? -x : x;
  endfunction

  function automatic bit agree(input wide_t a, input wide_t b);
    return (a > 0 && b > 0) || (a < 0 && b < 0);
  endfunction

  function automatic wide_t smooth(input wide_t x, input wide_t last, input wide_t rc,
                                   input wide_t dt);
    return sat((x * dt + last * rc) / (rc + dt));
  endfunction

  // One controller step: updates the bench state and returns drive and stall flag.
  function automatic ctrl_out_t pid_step(input sample_t it);
    wide_t meas, tgt, dt, err, e_int, pout, iterm, dout, sum, t_i, t_o, m;
    wide_t ca, cb;
    ctrl_out_t r;
    meas = it.measured;
    tgt  = it.target;
    dt   = {65'd0, it.elapsed};
    ca   = DefRateCoefA;
    cb   = DefRateCoefB;
    if (dt == 0) dt = 1;

    // Stall detection works on the values stored by the previous step.
    if (opts[OPT_STALL]) begin
      if (!(mag(last_drive) * 1000 < lim || mag(ref_hold) * 10000 < 65536)) begin
        if (20 * mag(ref_hold - last_meas) > 19 * mag(ref_hold)) begin
          if (stall_cnt < 1023) stall_cnt++;
        end else begin
          stall_cnt = 0;
          stall_on  = 1'b0;
        end
        if (stall_cnt > 500) stall_on = 1'b1;
      end
    end

    err = sat(tgt - meas);
    if (mag(err) > dband) begin
      pout  = sat((kp * err) >>> 16);
      e_int = opts[OPT_TRAP] ? (err + err_prev) >>> 1 : err;
      iterm = sat((sat((ki * e_int) >>> 16) * dt) >>> 16);
      dout  = sat(kd * (err - err_prev) / dt);
      if (opts[OPT_VRATE] && agree(err, i_acc)) begin
        m = mag(err);
        if (m > cb) iterm = (m <= ca + cb) ? iterm * (ca + cb - m) / ca : 0;
      end
      if (opts[OPT_DMEAS]) dout = sat(kd * (last_meas - meas) / dt);
      if (opts[OPT_DFILT]) dout = smooth(dout, d_hold, DefDerivFilterRc, dt);
      if (opts[OPT_ILIMIT]) begin
        t_i = i_acc + iterm;
        t_o = pout + i_acc + dout;
        if (mag(t_o) > lim && agree(err, i_acc)) iterm = 0;
        if (t_i > icap) begin
          iterm = 0;
          i_acc = icap;
        end
        if (t_i < -icap) begin
          iterm = 0;
          i_acc = -icap;
        end
      end
      i_acc = sat(i_acc + iterm);
      sum   = sat(pout + i_acc + dout);
      if (opts[OPT_OFILT]) sum = smooth(sum, last_drive, DefOutFilterRc, dt);
      if (sum > lim) sum = lim;
      if (sum < -lim) sum = -lim;
      d_hold = dout;
    end else begin
      sum = 0;
    end

    ref_hold   = stall_on ? sat(-tgt) : tgt;
    last_meas  = meas;
    last_drive = sum;
    err_prev   = err;
    r.drive    = sum[31:0];
    r.stalled  = stall_on;
    return r;
  endfunction

  // APB write; the bench copy of the register follows the write.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= AddrW'(idx) << 2;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GAIN_P:  kp    = {65'd0, val[30:0]};
      REG_GAIN_I:  ki    = {65'd0, val[30:0]};
      REG_GAIN_D:  kd    = {65'd0, val[30:0]};
      REG_OUT_LIM: lim   = {65'd0, val[30:0]};
      REG_INT_CAP: icap  = {65'd0, val[30:0]};
      REG_DEAD:    dband = {65'd0, val[30:0]};
      REG_OPTIONS: opts  = val[OptW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
                           input logic [31:0] l, input logic [31:0] c, input logic [31:0] b,
                           input logic [31:0] o);
    reg_write(REG_GAIN_P, p);
    reg_write(REG_GAIN_I, i);
    reg_write(REG_GAIN_D, d);
    reg_write(REG_OUT_LIM, l);
    reg_write(REG_INT_CAP, c);
    reg_write(REG_DEAD, b);
    reg_write(REG_OPTIONS, o);
  endtask

  // Wait until every queued request is sent and every result is back.
  task automatic drain();
    while (pending_samples.size() > 0 || s_tvalid || expected_drives.size() > 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic add(input logic [31:0] me, input logic [31:0] tg, input logic [30:0] dt,
                     input bit hold = 0);
    sample_t s;
    s.measured = me;
    s.target   = tg;
    s.elapsed  = dt;
    s.hold     = hold;
    pending_samples.push_back(s);
  endtask

  // A mix of full-range, modest Q16.16, extreme and zero values.
  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 4))
      0, 1: return $urandom();
      2: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 22)
                                     : -$urandom_range(0, 1 << 22);
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic [30:0] rand_dt();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(1, 32'h7FFF_FFFF));
      1: return 31'($urandom_range(1, 64));
      default: return 31'($urandom_range(1 << 8, 1 << 18));
    endcase
  endfunction

  function automatic logic [31:0] rand_reg();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'($urandom_range(0, 1 << 20));
      2: return 32'd0;
      default: return {1'b0, 31'($urandom())};
    endcase
  endfunction

  // Sender: inputs change on the falling edge.
  always @(negedge clk) begin
    bit nv;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nv = s_tvalid && !s_took;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_samples.size() > 0 &&
                     !(pending_samples[0].hold && (expected_drives.size() > 0 || s_took))) begin
          cur      = pending_samples.pop_front();
          nv       = 1'b1;
          send_gap = idle_on ? $urandom_range(0, 10) : 0;
          s_tdata  <= {1'b0, cur.elapsed, cur.target, cur.measured};
        end
      end
      s_tvalid <= nv;
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (m_took) recv_stall = idle_on ? $urandom_range(0, 10) : 0;
    if (recv_stall > 0) begin
      m_tready <= 1'b0;
      recv_stall--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    ctrl_out_t want;
    s_took = !rst && s_tvalid && s_tready;
    m_took = !rst && m_tvalid && m_tready;
    if (s_took) begin
      expected_drives.push_back(pid_step(cur));
      n_sent++;
    end
    if (m_took) begin
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result drive=%h stalled=%b", m_tdata, m_tuser);
      end else begin
        want = expected_drives.pop_front();
        n_checked++;
        if (want.stalled) n_stalled++;
        if (m_tdata !== want.drive || m_tuser !== want.stalled) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d: drive %h stalled %b, expected drive %h stalled %b",
                     n_checked, m_tdata, m_tuser, want.drive, want.stalled);
        end
      end
    end
  end

  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    s_tvalid = 0; s_tdata = '0; m_tready = 0; rst = 1;
    s_took = 0; m_took = 0; send_gap = 0; recv_stall = 0; idle_on = 1;
    mismatches = 0; n_sent = 0; n_checked = 0; n_stalled = 0;
    kp = 0; ki = 0; kd = 0; lim = 0; icap = 0; dband = 0; opts = '0;
    err_prev = 0; last_meas = 0; last_drive = 0; d_hold = 0; i_acc = 0; ref_hold = 0;
    stall_cnt = 0; stall_on = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Registers at their reset values: zero error and opposing extremes.
    add(32'd0, 32'd0, 31'd1);
    add(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    drain();

    // Plain PID with directed extremes of every field.
    idle_on = 0;
    load_regs(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0100_0000, 32'h0080_0000,
              32'h0000_0100, 32'd0);
    add(32'h8000_0000, 32'h7FFF_FFFF, 31'd1);
    add(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
    add(32'h0000_0000, 32'h0000_0080, 31'h0001_0000);
    add(32'h0000_0000, 32'h0000_0100, 31'h0001_0000);
    add(32'h0000_0000, 32'h0000_0101, 31'h0001_0000);
    add(32'hFFFF_FFFF, 32'h0000_0000, 31'h0000_0100);
    add(32'h0001_0000, 32'h0003_0000, 31'h0000_0400, 1);
    drain();

    // Each option alone, then all together with the largest gains, limits and cap.
    idle_on = 1;
    for (int b = 0; b <= OptW; b++) begin
      if (b == OptW)
        load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'd0, 32'h7F);
      else
        load_regs(32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'h0040_0000, 32'h0001_8000,
                  32'd0, 32'd1 << b);
      add(32'h0000_0000, 32'h0001_8000, 31'h0000_1000);
      add(32'h0000_4000, 32'h0001_8000, 31'h0000_1000);
      add(32'h0002_0000, 32'hFFFF_0000, 31'h0000_0100);
      add(32'h8000_0000, 32'h7FFF_FFFF, 31'd1);
      add(32'h0000_0000, 32'h0000_8000, 31'h0001_0000);
      drain();
    end

    // Blocked motor: a large reference that the measurement never follows.
    load_regs(32'h0001_0000, 32'd0, 32'd0, 32'h0010_0000, 32'd0, 32'd0, 32'h01);
    for (int k = 0; k < 560; k++)
      add(32'($urandom_range(0, 255)), 32'h0064_0000, rand_dt());
    // Measurement reaches the inverted reference: the flag clears again.
    for (int k = 0; k < 10; k++) add(32'hFF9C_0000, 32'h0064_0000, 31'h0001_0000);
    drain();

    // Random phases with random settings.
    for (int ph = 0; ph < 12; ph++) begin
      idle_on = (ph % 4 != 3);
      load_regs(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                $urandom_range(0, 2) == 0 ? rand_reg() : 32'($urandom_range(0, 1 << 12)),
                32'($urandom_range(0, 127)));
      for (int k = 0; k < 100; k++)
        add(rand_val(), rand_val(), rand_dt(), k == 50);
      drain();
    end

    $display("Sent %0d requests over 23 register settings and every option;", n_sent);
    $display("checked %0d results, %0d of them with the stall flag set.", n_checked, n_stalled);
    if (mismatches == 0) begin
      $display("positional_pid_with_options: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("positional_pid_with_options: mismatch");
    end
    $finish;
  end

endmodule
